@@ sv/ssort_pkg.sv @@
// shared constants and controller-to-datapath command types for the selection sorter
`default_nettype none

package ssort_pkg;

   localparam int unsigned DEPTH_DEFAULT = 8;
   localparam int unsigned DATA_W        = 32;

   // source of the word written into the element store
   typedef enum logic [1:0] {
      WR_INPUT,
      WR_BEST,
      WR_HELD
   } wr_src_type;

   typedef struct packed {
      logic       wr_en;
      wr_src_type wr_src;
      logic       rd_en;
      logic       rd_first;
      logic       load_out;
      logic       out_final;
   } dp_cmd_type;

endpackage

`default_nettype wire

@@ sv/ssort_if.sv @@
// valid/ready stream interfaces for the sorter's request and response channels
`default_nettype none

interface ssort_req_if import ssort_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface ssort_rsp_if import ssort_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sorted_value;
   logic                     final_res;

   modport source (output valid, output sorted_value, output final_res, input ready);
   modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

`default_nettype wire

@@ sv/ssort_dpath.sv @@
// sorter datapath: element store, running minimum and output register
`default_nettype none

module ssort_dpath import ssort_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT,
   localparam int unsigned IDX_W = $clog2(DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dp_cmd_type               cmd,
   input  wire logic [IDX_W-1:0]         rd_addr,
   input  wire logic [IDX_W-1:0]         wr_addr,
   input  wire logic signed [DATA_W-1:0] in_value,
   output logic signed [DATA_W-1:0]      out_value,
   output logic                          out_final
);

   logic signed [DATA_W-1:0] store_mem [DEPTH];

   logic signed [DATA_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]         rd_addr_ff;
   logic                     rd_valid_ff;
   logic                     rd_first_ff;

   logic signed [DATA_W-1:0] best_val_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic signed [DATA_W-1:0] held_val_ff;

   logic signed [DATA_W-1:0] out_value_ff;
   logic                     out_final_ff;

   logic [IDX_W-1:0]         wr_idx_in;
   logic signed [DATA_W-1:0] wr_data_in;

   always_comb begin
      wr_idx_in  = wr_addr;
      wr_data_in = in_value;
      unique case (cmd.wr_src)
         WR_INPUT: begin
            wr_data_in = in_value;
         end
         WR_BEST: begin
            wr_data_in = best_val_ff;
         end
         WR_HELD: begin
            // old occupant of the position goes where the minimum was found
            wr_idx_in  = best_idx_ff;
            wr_data_in = held_val_ff;
         end
         default: begin
            wr_data_in = in_value;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_mem[wr_idx_in] <= wr_data_in;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
      rd_addr_ff  <= rd_addr;
      rd_first_ff <= cmd.rd_first;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
      end
   end

   // running minimum over the beats read back in one pass
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         if (rd_first_ff) begin
            best_val_ff <= rd_data_ff;
            best_idx_ff <= rd_addr_ff;
            held_val_ff <= rd_data_ff;
         end else if (rd_data_ff < best_val_ff) begin
            best_val_ff <= rd_data_ff;
            best_idx_ff <= rd_addr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_value_ff <= best_val_ff;
         out_final_ff <= cmd.out_final;
      end
   end

   assign out_value = out_value_ff;
   assign out_final = out_final_ff;

endmodule

`default_nettype wire

@@ sv/ssort_ctrl.sv @@
// sorter controller: load, scan, swap and emit sequencing
`default_nettype none

module ssort_ctrl import ssort_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT,
   localparam int unsigned IDX_W = $clog2(DEPTH)
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_last,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output dp_cmd_type        cmd,
   output logic [IDX_W-1:0]  rd_addr,
   output logic [IDX_W-1:0]  wr_addr
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_SWAP_LO,
      ST_SWAP_HI,
      ST_EMIT
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] cnt_ff;
   logic [IDX_W-1:0] last_ff;
   logic [IDX_W-1:0] pos_ff;
   logic [IDX_W-1:0] scan_ff;
   logic             rsp_valid_ff;

   logic             emit_go;
   logic             set_end;

   assign emit_go = !rsp_valid_ff || rsp_ready;
   assign set_end = req_last || (cnt_ff == IDX_W'(DEPTH - 1));

   always_comb begin
      cmd     = '0;
      rd_addr = scan_ff;
      wr_addr = pos_ff;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.wr_en  = req_valid;
            cmd.wr_src = WR_INPUT;
            wr_addr    = cnt_ff;
         end
         ST_SCAN: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_first = (scan_ff == pos_ff);
         end
         ST_DRAIN: begin
            cmd.rd_en = 1'b0;
         end
         ST_SWAP_LO: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WR_BEST;
         end
         ST_SWAP_HI: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WR_HELD;
         end
         ST_EMIT: begin
            cmd.load_out  = emit_go;
            cmd.out_final = (pos_ff == last_ff);
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new beat enters the output register, or the held one leaves
         if (state_ff == ST_EMIT && emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_valid) begin
                  if (set_end) begin
                     last_ff  <= cnt_ff;
                     pos_ff   <= '0;
                     scan_ff  <= '0;
                     cnt_ff   <= '0;
                     state_ff <= ST_SCAN;
                  end else begin
                     cnt_ff <= cnt_ff + IDX_W'(1);
                  end
               end
            end
            ST_SCAN: begin
               if (scan_ff == last_ff) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  scan_ff <= scan_ff + IDX_W'(1);
               end
            end
            ST_DRAIN: begin
               // last read beat settles into the running minimum
               state_ff <= ST_SWAP_LO;
            end
            ST_SWAP_LO: begin
               state_ff <= ST_SWAP_HI;
            end
            ST_SWAP_HI: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_go) begin
                  if (pos_ff == last_ff) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     pos_ff   <= pos_ff + IDX_W'(1);
                     scan_ff  <= pos_ff + IDX_W'(1);
                     state_ff <= ST_SCAN;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ sv/selection_sorter.sv @@
// top level of the selection sorter: controller plus datapath
//
//   channel  dir  beat fields              handshake
//   req_if   in   value[31:0], last        valid/ready
//   rsp_if   out  sorted_value[31:0],      valid/ready
//                 final_res
//
// a set of n items loads one beat per cycle while the controller is in its load state
// each pass of the sort reads every remaining element once on the single read
// port of the store, then takes one drain step, two swap writes and one emit
// responses stall the emit step only
// reset is synchronous and clears the controller; the store is not cleared
`default_nettype none

module selection_sorter import ssort_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ssort_req_if.sink  req_if,
   ssort_rsp_if.source rsp_if
);

   localparam int unsigned IDX_W = $clog2(DEPTH);

   dp_cmd_type       cmd;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;

   ssort_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr)
   );

   ssort_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .in_value  (req_if.value),
      .out_value (rsp_if.sorted_value),
      .out_final (rsp_if.final_res)
   );

endmodule

`default_nettype wire

@@ sv/ssort_checker.sv @@
// port-level checks for the selection sorter and their bind
`default_nettype none

module ssort_checker import ssort_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     req_last,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [DATA_W-1:0] rsp_sorted_value,
   input wire logic                     rsp_final_res
);

   logic signed [DATA_W-1:0] prev_ff;
   logic                     mid_run_ff;

   // track the previous response beat within a run
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_run_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         mid_run_ff <= !rsp_final_res;
         prev_ff    <= rsp_sorted_value;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_value)
                                  && $stable(rsp_final_res))
      else $error("response beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("request taken right after the end of a set");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && mid_run_ff |-> rsp_sorted_value >= prev_ff)
      else $error("response run not ascending");

endmodule

bind selection_sorter ssort_checker u_ssort_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .req_last         (req_if.last),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_sorted_value (rsp_if.sorted_value),
   .rsp_final_res    (rsp_if.final_res)
);

`default_nettype wire

@@ tb/sv/tb_selection_sorter.sv @@
// self-checking testbench for the selection sorter: random sets, stalls and a sorting predictor
module tb_selection_sorter import ssort_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH       = DEPTH_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE      = 100;
   localparam int unsigned RANDOM_ITEMS = 200;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     last;
      int unsigned              gap;
      bit                       drain;
   } element_beat_type;

   typedef struct {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     final_res;
   } sorted_beat_type;

   logic clock;
   logic reset;

   ssort_req_if req_if ();
   ssort_rsp_if rsp_if ();

   selection_sorter #(.DEPTH(DEPTH)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   element_beat_type         unsent_q[$];
   sorted_beat_type          sorted_q[$];
   logic signed [DATA_W-1:0] held_vals[DEPTH];
   int unsigned              held_count = 0;
   int                       results_pending = 0;
   int unsigned              mismatch_count = 0;
   int unsigned              idle_cycles = 0;
   int unsigned              stall_left = 0;
   int unsigned              rsp_beats = 0;
   int unsigned              cycle_count = 0;

   // keeps the current set; on its end sorts it and queues the ordered run
   function automatic void take_element(input logic signed [DATA_W-1:0] v, input logic mark);
      logic signed [DATA_W-1:0] swap_val;
      int unsigned              best;
      held_vals[held_count] = v;
      held_count++;
      if (mark || held_count == DEPTH) begin
         for (int unsigned pos = 0; pos + 1 < held_count; pos++) begin
            best = pos;
            for (int unsigned scan = pos + 1; scan < held_count; scan++)
               if (held_vals[scan] < held_vals[best]) best = scan;
            swap_val        = held_vals[pos];
            held_vals[pos]  = held_vals[best];
            held_vals[best] = swap_val;
         end
         for (int unsigned k = 0; k < held_count; k++)
            sorted_q.push_back('{held_vals[k], k + 1 == held_count});
         held_count = 0;
      end
   endfunction

   function automatic void add_element(input logic signed [DATA_W-1:0] v, input logic mark,
                                       input int unsigned gap, input bit drain);
      unsent_q.push_back('{v, mark, gap, drain});
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value(input int unsigned flavor);
      case (flavor)
         0: return $urandom;
         1: return int'($urandom_range(0, 6)) - 3;
         2: begin
            case ($urandom_range(0, 5))
               0: return 32'sh8000_0000;
               1: return 32'sh8000_0001;
               2: return 32'sh7fff_ffff;
               3: return 32'sh7fff_fffe;
               4: return 32'sh0000_0000;
               default: return -32'sd1;
            endcase
         end
         default: return ($urandom_range(0, 1) != 0) ? $urandom
                                                     : int'($urandom_range(0, 20)) - 10;
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // driver: presents the head of the queue after its gap, optionally after a full drain
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         idle_cycles  <= 0;
      end else if (req_if.valid && !req_if.ready) begin
         // beat still waiting
      end else if (unsent_q.size() != 0 && idle_cycles >= unsent_q[0].gap &&
                   (!unsent_q[0].drain || (results_pending == 0 && idle_cycles != 0))) begin
         req_if.valid <= 1'b1;
         req_if.value <= unsent_q[0].value;
         req_if.last  <= unsent_q[0].last;
         void'(unsent_q.pop_front());
         idle_cycles  <= 0;
      end else begin
         req_if.valid <= 1'b0;
         idle_cycles  <= idle_cycles + 1;
      end
   end

   // receiver: random stalls per beat, with calm stretches every few dozen beats
   always @(posedge clock) begin
      int unsigned stall_draw;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         rsp_beats  <= rsp_beats + 1;
         stall_draw = ((rsp_beats / 40) % 3 == 1) ? 0 : $urandom_range(0, 4);
         if (stall_draw == 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_draw;
         end
      end else if (!rsp_if.ready) begin
         if (stall_left <= 1) begin
            rsp_if.ready <= 1'b1;
            stall_left   <= 0;
         end else begin
            stall_left <= stall_left - 1;
         end
      end
   end

   // monitor: checks output beats against the ordered run, feeds accepted input beats
   always @(posedge clock) begin
      sorted_beat_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (sorted_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected beat: expected none, actual value %0d final %0b",
                        $time, rsp_if.sorted_value, rsp_if.final_res);
            end else begin
               want = sorted_q.pop_front();
               if (rsp_if.sorted_value !== want.sorted_value) begin
                  mismatch_count++;
                  $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                           $time, want.sorted_value, rsp_if.sorted_value);
               end
               if (rsp_if.final_res !== want.final_res) begin
                  mismatch_count++;
                  $display("%0t: final_res mismatch: expected %0b, actual %0b",
                           $time, want.final_res, rsp_if.final_res);
               end
            end
         end
         if (req_if.valid && req_if.ready) take_element(req_if.value, req_if.last);
      end
      results_pending <= sorted_q.size();
   end

   initial begin
      int unsigned              items_made;
      int unsigned              set_len;
      int unsigned              flavor;
      logic                     mark_end;
      bit                       calm;
      logic signed [DATA_W-1:0] v;

      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.value = '0;
      req_if.last  = 1'b0;
      rsp_if.ready = 1'b0;

      // single-element sets at both extremes
      add_element(32'sh7fff_ffff, 1'b1, $urandom_range(0, 4), 1'b0);
      add_element(32'sh8000_0000, 1'b1, $urandom_range(0, 4), 1'b0);
      // full store with no mark, after a complete drain; duplicates and extremes
      add_element(32'sh0000_0000, 1'b0, 0, 1'b1);
      add_element(-32'sd1,        1'b0, $urandom_range(0, 4), 1'b0);
      add_element(32'sh7fff_ffff, 1'b0, $urandom_range(0, 4), 1'b0);
      add_element(32'sh8000_0000, 1'b0, $urandom_range(0, 4), 1'b0);
      add_element(32'sd1,         1'b0, $urandom_range(0, 4), 1'b0);
      add_element(-32'sd1,        1'b0, $urandom_range(0, 4), 1'b0);
      add_element(32'sh8000_0000, 1'b0, $urandom_range(0, 4), 1'b0);
      add_element(32'sh1234_5678, 1'b0, $urandom_range(0, 4), 1'b0);
      // equal pair
      add_element(32'sd5, 1'b0, $urandom_range(0, 4), 1'b0);
      add_element(32'sd5, 1'b1, $urandom_range(0, 4), 1'b0);
      // descending triple
      add_element(32'sd300,  1'b0, 0, 1'b0);
      add_element(32'sd200,  1'b0, 0, 1'b0);
      add_element(-32'sd100, 1'b1, 0, 1'b0);
      // already ascending, marked on the last slot of the store
      for (int i = 0; i < DEPTH; i++)
         add_element(i * 3 - 10, i == DEPTH - 1, $urandom_range(0, 2), 1'b0);

      items_made = 0;
      while (items_made < RANDOM_ITEMS) begin
         set_len  = ($urandom_range(0, 4) == 0) ? DEPTH : $urandom_range(1, DEPTH);
         mark_end = (set_len < DEPTH) ? 1'b1 : logic'($urandom_range(0, 1));
         flavor   = $urandom_range(0, 3);
         calm     = ((items_made / 50) % 2 == 1);
         for (int unsigned i = 0; i < set_len; i++) begin
            v = pick_value(flavor);
            add_element(v, (i + 1 == set_len) ? mark_end : 1'b0,
                        calm ? 0 : $urandom_range(0, 4),
                        i == 0 && $urandom_range(0, 9) == 0);
         end
         items_made += set_len;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (unsent_q.size() != 0 || req_if.valid || results_pending != 0);
      repeat (SETTLE) @(posedge clock);

      if (mismatch_count == 0 && sorted_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
